// ===== src/ic5_pkg.sv =====
package ic5_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD_COEF   = 2'd0;
	localparam logic [1:0] CMD_WRITE_PIXEL = 2'd1;
	localparam logic [1:0] CMD_COMPUTE     = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam int ADDR_W    = 3;
	localparam int DIM_W     = 9;
	localparam int CHAN_W    = 8;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 10;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} mac_ctrl_t;

endpackage

// ===== src/ic5_cmd_if.sv =====
interface ic5_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         command;
	logic [7:0]                         pos_x;
	logic [7:0]                         pos_y;
	logic [ic5_pkg::CHAN_W-1:0]         pixel_red;
	logic [ic5_pkg::CHAN_W-1:0]         pixel_green;
	logic [ic5_pkg::CHAN_W-1:0]         pixel_blue;
	logic [4:0]                         coef_index;
	logic signed [ic5_pkg::COEF_W-1:0]  coef_value;

	modport source (
		output valid, command, pos_x, pos_y, pixel_red, pixel_green, pixel_blue,
		       coef_index, coef_value,
		input  ready
	);
	modport sink (
		input  valid, command, pos_x, pos_y, pixel_red, pixel_green, pixel_blue,
		       coef_index, coef_value,
		output ready
	);
endinterface

// ===== src/ic5_res_if.sv =====
interface ic5_res_if;
	logic                       valid;
	logic                       ready;
	logic [ic5_pkg::CHAN_W-1:0] result_red;
	logic [ic5_pkg::CHAN_W-1:0] result_green;
	logic [ic5_pkg::CHAN_W-1:0] result_blue;

	modport source (
		output valid, result_red, result_green, result_blue,
		input  ready
	);
	modport sink (
		input  valid, result_red, result_green, result_blue,
		output ready
	);
endinterface

// ===== src/ic5_mac.sv =====
module ic5_mac #(
	parameter int TAPS = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ic5_pkg::mac_ctrl_t                ctrl,
	input  ic5_pkg::rgb_t                     pix,
	input  logic signed [ic5_pkg::COEF_W-1:0] coef,
	output logic                              done,
	output ic5_pkg::rgb_t                     result
);

	localparam int PROD_W = ic5_pkg::CHAN_W + 1 + ic5_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam int LSB    = ic5_pkg::FRAC_BITS;

	logic signed [PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic                     valid_s2, last_s2;
	logic signed [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;
	logic                     done_q;

	// truncate toward zero, clamp to 0..255
	function automatic logic [ic5_pkg::CHAN_W-1:0] finish(input logic signed [ACC_W-1:0] a);
		logic [ic5_pkg::CHAN_W-1:0] r;
		if (a[ACC_W-1])
			r = '0;
		else if (|a[ACC_W-2:LSB+ic5_pkg::CHAN_W])
			r = '1;
		else
			r = a[LSB+ic5_pkg::CHAN_W-1:LSB];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid;
			last_s2  <= ctrl.valid && ctrl.last;
			if (ctrl.clear)
				done_q <= 1'b0;
			else if (valid_s2 && last_s2)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_r_s2 <= $signed({1'b0, pix.red})   * coef;
		prod_g_s2 <= $signed({1'b0, pix.green}) * coef;
		prod_b_s2 <= $signed({1'b0, pix.blue})  * coef;
		if (ctrl.clear) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (valid_s2) begin
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
			acc_g_q <= acc_g_q + ACC_W'(prod_g_s2);
			acc_b_q <= acc_b_q + ACC_W'(prod_b_s2);
		end
	end

	assign done         = done_q;
	assign result.red   = finish(acc_r_q);
	assign result.green = finish(acc_g_q);
	assign result.blue  = finish(acc_b_q);

endmodule

// ===== src/image_convolution_5x5.sv =====
// RGB frame store with a KERNEL_SIDE x KERNEL_SIDE convolution engine (signed Q5.10
// coefficients, replicated border, channels truncated and clamped to 0..255).
// Coefficient loads and pixel writes complete when accepted and may follow back to
// back. A compute transaction reads one tap per cycle from the single-port frame
// memory, so it holds the input while it reads all KERNEL_SIDE*KERNEL_SIDE taps
// (25 by default) and until their multiply/accumulate result lands in the output
// register; the input reopens once that register is free. Only compute produces a
// result. The frame memory is not initialized: read only written pixels.
// The coefficient store reads as zero after reset with no clearing pass.
module image_convolution_5x5 #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int KERNEL_SIDE = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ic5_cmd_if.sink                    cmd,
	ic5_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ic5_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int TAPS = KERNEL_SIDE * KERNEL_SIDE;
	localparam int TW   = $clog2(TAPS);
	localparam int KW   = $clog2(KERNEL_SIDE);
	localparam int CTR  = KERNEL_SIDE / 2;
	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT);
	localparam int AW   = XW + YW;
	localparam int DW   = ic5_pkg::DIM_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]    state_q;
	logic [DW-1:0] width_q, height_q, w_eff, h_eff;
	logic [7:0]    x_q, y_q;
	logic [KW-1:0] i_q, j_q;
	logic [TW-1:0] tap_q;
	logic          cmd_acc, cfg_wr, issue, tap_last;
	logic          valid_s1, last_s1;
	logic [DW-1:0] cx, cy;

	ic5_pkg::rgb_t                     frame_mem [2**AW];
	ic5_pkg::rgb_t                     pix_s1;
	logic [AW-1:0]                     frame_addr;
	logic                              frame_we;

	logic signed [ic5_pkg::COEF_W-1:0] coef_mem [TAPS];
	logic [TAPS-1:0]                   coef_vld_q;
	logic signed [ic5_pkg::COEF_W-1:0] coef_s1, coef_use;
	logic                              coef_ok_s1;
	logic [TW-1:0]                     coef_addr;
	logic                              coef_we;

	ic5_pkg::mac_ctrl_t ctrl;
	ic5_pkg::rgb_t      mac_result;
	logic               mac_done;
	logic               out_valid_q, out_load;
	ic5_pkg::rgb_t      out_q;

	// clamp p + k - CTR into 0..lim-1
	function automatic logic [DW-1:0] clamp_coord(input logic [7:0] p, input logic [KW-1:0] k,
			input logic [DW-1:0] lim);
		logic [DW+1:0] r;
		logic [DW-1:0] c;
		r = (DW+2)'(p) + (DW+2)'(k) - (DW+2)'(CTR);
		if (r[DW+1])
			c = '0;
		else if (r >= (DW+2)'(lim))
			c = lim - DW'(1);
		else
			c = r[DW-1:0];
		return c;
	endfunction

	// APB registers
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(256);
			height_q <= DW'(256);
		end else if (cfg_wr) begin
			if (paddr[2] == ic5_pkg::REG_IMAGE_HEIGHT)
				height_q <= pwdata[DW-1:0];
			else
				width_q <= pwdata[DW-1:0];
		end
	end

	assign prdata = {(32-DW)'(0), (paddr[2] == ic5_pkg::REG_IMAGE_HEIGHT) ? height_q : width_q};

	always_comb begin
		if (width_q == '0)
			w_eff = DW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = DW'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = DW'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = DW'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// command side
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign issue     = (state_q == ST_RUN);
	assign tap_last  = (tap_q == TW'(TAPS - 1));
	assign out_load  = (state_q == ST_WAIT) && mac_done && (!out_valid_q || res.ready);

	assign cx = clamp_coord(x_q, i_q, w_eff);
	assign cy = clamp_coord(y_q, j_q, h_eff);

	assign frame_we = cmd_acc && (cmd.command == ic5_pkg::CMD_WRITE_PIXEL)
		&& (DW'(cmd.pos_x) < w_eff) && (DW'(cmd.pos_y) < h_eff);
	assign frame_addr = issue ? {YW'(cy), XW'(cx)} : {YW'(cmd.pos_y), XW'(cmd.pos_x)};

	assign coef_we = cmd_acc && (cmd.command == ic5_pkg::CMD_LOAD_COEF)
		&& (32'(cmd.coef_index) < TAPS);
	assign coef_addr = issue ? tap_q : TW'(cmd.coef_index);

	always_ff @(posedge clk) begin
		if (frame_we)
			frame_mem[frame_addr] <= '{blue: cmd.pixel_blue, green: cmd.pixel_green,
				red: cmd.pixel_red};
		else
			pix_s1 <= frame_mem[frame_addr];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_addr] <= cmd.coef_value;
		else
			coef_s1 <= coef_mem[coef_addr];
		coef_ok_s1 <= coef_vld_q[coef_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coef_vld_q <= '0;
		else if (coef_we)
			coef_vld_q[coef_addr] <= 1'b1;
	end

	assign coef_use = coef_ok_s1 ? coef_s1 : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			tap_q       <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			last_s1  <= issue && tap_last;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.command == ic5_pkg::CMD_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						tap_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					tap_q <= tap_q + TW'(1);
					if (j_q == KW'(KERNEL_SIDE - 1)) begin
						j_q <= '0;
						i_q <= i_q + KW'(1);
					end else begin
						j_q <= j_q + KW'(1);
					end
					if (tap_last)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			x_q <= cmd.pos_x;
			y_q <= cmd.pos_y;
		end
		if (out_load)
			out_q <= mac_result;
	end

	assign ctrl.clear = cmd_acc && (cmd.command == ic5_pkg::CMD_COMPUTE);
	assign ctrl.valid = valid_s1;
	assign ctrl.last  = last_s1;

	ic5_mac #(
		.TAPS(TAPS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pix    (pix_s1),
		.coef   (coef_use),
		.done   (mac_done),
		.result (mac_result)
	);

	assign res.valid        = out_valid_q;
	assign res.result_red   = out_q.red;
	assign res.result_green = out_q.green;
	assign res.result_blue  = out_q.blue;

endmodule
